/* rtl/core/acs_pkg.sv */
package acs_pkg;

  localparam int WORD_W       = 32;
  localparam int FIELD_ADDR_W = 16;
  localparam int PLEN_W       = 17;
  localparam int CFG_IDX_W    = 1;
  localparam int OPC_W        = 8;
  localparam int FIFO_CNT_W   = 2;

  localparam logic [FIELD_ADDR_W-1:0] SP_RESET = 16'd4096;

  typedef enum logic [OPC_W-1:0] {
    OPC_LDC    = 8'd0,
    OPC_ADC    = 8'd1,
    OPC_LDL    = 8'd2,
    OPC_STL    = 8'd3,
    OPC_LDNL   = 8'd4,
    OPC_STNL   = 8'd5,
    OPC_ADD    = 8'd6,
    OPC_SUB    = 8'd7,
    OPC_SHL    = 8'd8,
    OPC_SHR    = 8'd9,
    OPC_ADJ    = 8'd10,
    OPC_A2SP   = 8'd11,
    OPC_SP2A   = 8'd12,
    OPC_CALL   = 8'd13,
    OPC_RETURN = 8'd14,
    OPC_BRZ    = 8'd15,
    OPC_BRLZ   = 8'd16,
    OPC_BR     = 8'd17,
    OPC_HALT   = 8'd18
  } opcode_t;

  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_HALT  = 2'd1,
    ST_BADOP = 2'd2,
    ST_SEGV  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROG_LEN = 1'b0,
    CFG_INIT_SP  = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    ITEM_LOAD = 1'b0,
    ITEM_STEP = 1'b1
  } item_op_t;

  typedef enum logic [1:0] {
    PH_CLEAR = 2'd0,
    PH_IDLE  = 2'd1,
    PH_EXEC  = 2'd2
  } phase_t;

  typedef struct packed {
    logic                     op;
    logic [FIELD_ADDR_W-1:0]  load_address;
    logic signed [WORD_W-1:0] data_word;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [FIELD_ADDR_W-1:0]  program_counter;
    logic [FIELD_ADDR_W-1:0]  stack_pointer;
    logic signed [WORD_W-1:0] reg_a;
    logic signed [WORD_W-1:0] reg_b;
    logic [WORD_W-1:0]        executed_count;
  } rsp_item_t;

  typedef struct packed {
    logic mem_we;
    logic mem_re;
    logic wb_load;
  } exec_ctl_t;

endpackage

/* rtl/core/acs_mem.sv */
module acs_mem #(
  parameter int ADDR_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         we,
  input  logic [ADDR_BITS-1:0]         waddr,
  input  logic [acs_pkg::WORD_W-1:0]   wdata,
  input  logic                         re,
  input  logic [ADDR_BITS-1:0]         raddr,
  output logic [acs_pkg::WORD_W-1:0]   rdata,
  output logic                         busy
);
  import acs_pkg::*;

  logic [WORD_W-1:0]    mem [2**ADDR_BITS];
  logic [ADDR_BITS-1:0] clr_ptr;
  logic                 clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_ptr  <= '0;
    end else if (clearing) begin
      clr_ptr <= clr_ptr + 1'b1;
      if (&clr_ptr) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_ptr] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  assign busy = clearing;

endmodule

/* rtl/core/acs_exec.sv */
module acs_exec #(
  parameter int ADDR_BITS = 16
) (
  input  logic [acs_pkg::WORD_W-1:0]        instr,
  input  acs_pkg::cmd_item_t                item,
  input  logic [ADDR_BITS-1:0]              pc,
  input  logic [ADDR_BITS-1:0]              sp,
  input  logic signed [acs_pkg::WORD_W-1:0] acc_a,
  input  logic signed [acs_pkg::WORD_W-1:0] acc_b,
  input  logic [acs_pkg::WORD_W-1:0]        count,
  input  acs_pkg::status_t                  status,
  input  logic [acs_pkg::PLEN_W-1:0]        plen,
  output logic [ADDR_BITS-1:0]              pc_next,
  output logic [ADDR_BITS-1:0]              sp_next,
  output logic signed [acs_pkg::WORD_W-1:0] a_next,
  output logic signed [acs_pkg::WORD_W-1:0] b_next,
  output logic [acs_pkg::WORD_W-1:0]        count_next,
  output acs_pkg::status_t                  status_next,
  output logic [ADDR_BITS-1:0]              mem_addr,
  output logic [acs_pkg::WORD_W-1:0]        mem_wdata,
  output acs_pkg::exec_ctl_t                ctl
);
  import acs_pkg::*;

  localparam int CMP_W = (ADDR_BITS > PLEN_W) ? ADDR_BITS : PLEN_W;

  logic [OPC_W-1:0]     opc_raw;
  opcode_t              opc;
  logic signed [WORD_W-1:0] opd;
  logic [ADDR_BITS-1:0] opd_addr;
  logic [ADDR_BITS-1:0] pc_seq;
  logic [ADDR_BITS-1:0] pc_jump;
  logic [ADDR_BITS-1:0] sp_rel;
  logic [ADDR_BITS-1:0] a_rel;
  logic                 pc_ok;

  assign opc_raw  = instr[OPC_W-1:0];
  assign opc      = opcode_t'(opc_raw);
  assign opd      = {{OPC_W{instr[WORD_W-1]}}, instr[WORD_W-1:OPC_W]};
  assign opd_addr = instr[OPC_W +: ADDR_BITS];
  assign pc_seq   = pc + 1'b1;
  assign pc_jump  = pc + opd_addr + 1'b1;
  assign sp_rel   = sp + opd_addr;
  assign a_rel    = acc_a[ADDR_BITS-1:0] + opd_addr;
  assign pc_ok    = CMP_W'(pc) < CMP_W'(plen);

  always_comb begin
    pc_next     = pc;
    sp_next     = sp;
    a_next      = acc_a;
    b_next      = acc_b;
    count_next  = count;
    status_next = status;
    mem_addr    = ADDR_BITS'(item.load_address);
    mem_wdata   = item.data_word;
    ctl         = '0;
    if (item.op == ITEM_LOAD) begin
      ctl.mem_we = 1'b1;
    end else if (status == ST_RUN) begin
      if (!pc_ok) begin
        status_next = ST_SEGV;
      end else if (opc_raw > OPC_HALT) begin
        status_next = ST_BADOP;
      end else if (opc == OPC_HALT) begin
        status_next = ST_HALT;
      end else begin
        count_next = count + 1'b1;
        pc_next    = pc_seq;
        case (opc)
          OPC_LDC: begin
            b_next = acc_a;
            a_next = opd;
          end
          OPC_ADC: a_next = acc_a + opd;
          OPC_LDL: begin
            b_next      = acc_a;
            mem_addr    = sp_rel;
            ctl.mem_re  = 1'b1;
            ctl.wb_load = 1'b1;
          end
          OPC_STL: begin
            mem_addr   = sp_rel;
            mem_wdata  = acc_a;
            ctl.mem_we = 1'b1;
            a_next     = acc_b;
          end
          OPC_LDNL: begin
            mem_addr    = a_rel;
            ctl.mem_re  = 1'b1;
            ctl.wb_load = 1'b1;
          end
          OPC_STNL: begin
            mem_addr   = a_rel;
            mem_wdata  = acc_b;
            ctl.mem_we = 1'b1;
          end
          OPC_ADD: a_next = acc_b + acc_a;
          OPC_SUB: a_next = acc_b - acc_a;
          OPC_SHL: a_next = acc_b << acc_a[4:0];
          OPC_SHR: a_next = acc_b >>> acc_a[4:0];
          OPC_ADJ: sp_next = sp_rel;
          OPC_A2SP: begin
            sp_next = acc_a[ADDR_BITS-1:0];
            a_next  = acc_b;
          end
          OPC_SP2A: begin
            b_next = acc_a;
            a_next = WORD_W'(sp);
          end
          OPC_CALL: begin
            b_next  = acc_a;
            a_next  = WORD_W'(pc);
            pc_next = pc_jump;
          end
          OPC_RETURN: begin
            pc_next = acc_a[ADDR_BITS-1:0] + 1'b1;
            a_next  = acc_b;
          end
          OPC_BRZ: begin
            if (acc_a == '0) begin
              pc_next = pc_jump;
            end
          end
          OPC_BRLZ: begin
            if (acc_a[WORD_W-1]) begin
              pc_next = pc_jump;
            end
          end
          OPC_BR: pc_next = pc_jump;
          default: pc_next = pc_seq;
        endcase
      end
    end
  end

endmodule

/* rtl/core/acs_out_fifo.sv */
module acs_out_fifo (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  acs_pkg::rsp_item_t                 push_item,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output acs_pkg::rsp_item_t                 rsp_item,
  output logic [acs_pkg::FIFO_CNT_W-1:0]     fill
);
  import acs_pkg::*;

  rsp_item_t slot [2];
  logic      wr_ptr;
  logic      rd_ptr;
  logic      pop;

  assign rsp_valid = (fill != '0);
  assign rsp_item  = slot[rd_ptr];
  assign pop       = rsp_valid && !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_item;
    end
  end

endmodule

/* rtl/core/accumulator_stack_cpu_step_core.sv */
// Channel  Direction  Handshake              Beat
// cmd      in         cmd_valid / cmd_stall  one load or step item
// rsp      out        rsp_valid / rsp_stall  machine state after one item
// cfg      in         cfg_we                 one register write
//
// Items are taken only in the idle phase, and done in the execute phase: a step
// fetches its instruction from the word memory when taken, then does its data
// read or write there; a load writes its word. Stack and indirect loads write A
// in the next idle cycle, overlapping the next fetch. After reset the memory is
// swept to zero, word by word, before the first beat is taken.
// A two-entry result queue lets the core run on while a response is stalled.
module accumulator_stack_cpu_step_core #(
  parameter int ADDR_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  output logic                             cmd_stall,
  input  acs_pkg::cmd_item_t               cmd_item,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output acs_pkg::rsp_item_t               rsp_item,
  input  logic                             cfg_we,
  input  logic [acs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [acs_pkg::PLEN_W-1:0]       cfg_data
);
  import acs_pkg::*;

  phase_t                   phase;
  phase_t                   phase_next;
  cmd_item_t                item;
  logic                     wb_pending;
  logic [ADDR_BITS-1:0]     pc;
  logic [ADDR_BITS-1:0]     sp;
  logic signed [WORD_W-1:0] acc_a;
  logic signed [WORD_W-1:0] acc_b;
  logic [WORD_W-1:0]        count;
  status_t                  status;
  logic [PLEN_W-1:0]        plen;

  logic [ADDR_BITS-1:0]     pc_next;
  logic [ADDR_BITS-1:0]     sp_next;
  logic signed [WORD_W-1:0] a_next;
  logic signed [WORD_W-1:0] b_next;
  logic [WORD_W-1:0]        count_next;
  status_t                  status_next;
  logic [ADDR_BITS-1:0]     ex_addr;
  logic [WORD_W-1:0]        ex_wdata;
  exec_ctl_t                ctl;

  logic                     accept;
  logic                     in_exec;
  logic                     mem_we;
  logic                     mem_re;
  logic [ADDR_BITS-1:0]     mem_raddr;
  logic [WORD_W-1:0]        mem_rdata;
  logic                     mem_busy;
  logic                     rsp_push;
  rsp_item_t                push_item;
  logic [FIFO_CNT_W-1:0]    fifo_fill;
  logic [FIFO_CNT_W-1:0]    occupancy;

  assign occupancy = fifo_fill + FIFO_CNT_W'(wb_pending);
  assign cmd_stall = !((phase == PH_IDLE) && (occupancy < FIFO_CNT_W'(2)));
  assign accept    = cmd_valid && !cmd_stall;
  assign in_exec   = (phase == PH_EXEC);

  assign mem_we    = in_exec && ctl.mem_we;
  assign mem_re    = (accept && (cmd_item.op == ITEM_STEP)) || (in_exec && ctl.mem_re);
  assign mem_raddr = in_exec ? ex_addr : pc;

  acs_mem #(
    .ADDR_BITS (ADDR_BITS)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (ex_addr),
    .wdata (ex_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .busy  (mem_busy)
  );

  acs_exec #(
    .ADDR_BITS (ADDR_BITS)
  ) u_exec (
    .instr       (mem_rdata),
    .item        (item),
    .pc          (pc),
    .sp          (sp),
    .acc_a       (acc_a),
    .acc_b       (acc_b),
    .count       (count),
    .status      (status),
    .plen        (plen),
    .pc_next     (pc_next),
    .sp_next     (sp_next),
    .a_next      (a_next),
    .b_next      (b_next),
    .count_next  (count_next),
    .status_next (status_next),
    .mem_addr    (ex_addr),
    .mem_wdata   (ex_wdata),
    .ctl         (ctl)
  );

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_CLEAR: begin
        if (!mem_busy) begin
          phase_next = PH_IDLE;
        end
      end
      PH_IDLE: begin
        if (accept) begin
          phase_next = PH_EXEC;
        end
      end
      PH_EXEC: phase_next = PH_IDLE;
      default: phase_next = PH_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_CLEAR;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= cmd_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_pending <= 1'b0;
      pc         <= '0;
      sp         <= ADDR_BITS'(SP_RESET);
      acc_a      <= '0;
      acc_b      <= '0;
      count      <= '0;
      status     <= ST_RUN;
      plen       <= '0;
    end else begin
      wb_pending <= in_exec && ctl.wb_load;
      if (cfg_we && (cfg_index == CFG_PROG_LEN)) begin
        plen <= cfg_data;
      end
      if (cfg_we && (cfg_index == CFG_INIT_SP)) begin
        sp <= ADDR_BITS'(cfg_data[FIELD_ADDR_W-1:0]);
      end else if (in_exec) begin
        sp <= sp_next;
      end
      if (in_exec) begin
        pc     <= pc_next;
        acc_a  <= a_next;
        acc_b  <= b_next;
        count  <= count_next;
        status <= status_next;
      end else if (wb_pending) begin
        acc_a <= mem_rdata;
      end
    end
  end

  assign rsp_push = (in_exec && !ctl.wb_load) || wb_pending;

  always_comb begin
    if (wb_pending) begin
      push_item.status          = status;
      push_item.program_counter = FIELD_ADDR_W'(pc);
      push_item.stack_pointer   = FIELD_ADDR_W'(sp);
      push_item.reg_a           = mem_rdata;
      push_item.reg_b           = acc_b;
      push_item.executed_count  = count;
    end else begin
      push_item.status          = status_next;
      push_item.program_counter = FIELD_ADDR_W'(pc_next);
      push_item.stack_pointer   = FIELD_ADDR_W'(sp_next);
      push_item.reg_a           = a_next;
      push_item.reg_b           = b_next;
      push_item.executed_count  = count_next;
    end
  end

  acs_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (rsp_push),
    .push_item (push_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item),
    .fill      (fifo_fill)
  );

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    rsp_push |-> (fifo_fill != FIFO_CNT_W'(2)))
    else $error("Result queue written while full.");

  a_wb_slot: assert property (@(posedge clk) disable iff (rst)
    wb_pending |-> (phase == PH_IDLE))
    else $error("Load write-back overlaps an execute cycle.");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (phase == PH_EXEC))
    else $error("Accepted beat did not enter the execute cycle.");

  a_sticky_stop: assert property (@(posedge clk) disable iff (rst)
    (status != ST_RUN) |=> $stable(status))
    else $error("Stop status changed without reset.");
`endif

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import acs_pkg::*;

  typedef struct {
    cmd_item_t item;
    bit        has_want;
    rsp_item_t want;
  } script_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cmd_valid;
  logic                 cmd_stall;
  cmd_item_t            cmd_item;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  rsp_item_t            rsp_item;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PLEN_W-1:0]    cfg_data;

  logic [WORD_W-1:0]    shadow_mem [0:65535];
  rsp_item_t            cpu_state;
  logic [PLEN_W-1:0]    prog_len;
  rsp_item_t            pending_results [$];
  rsp_item_t            arrived;
  script_row_t          script [$];

  int send_idle_pct;
  int recv_idle_pct;
  int send_calm;
  int recv_calm;
  int failures;
  int beats_sent;
  int steps_sent;
  int results_seen;
  status_t closing_stop;

  accumulator_stack_cpu_step_core #(.ADDR_BITS(16)) uut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd_item(cmd_item),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_item(rsp_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

  // Applies one beat to the shadow machine and returns the state it reports.
  function automatic rsp_item_t execute_beat(cmd_item_t it);
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] opd;
    logic [OPC_W-1:0]  opc;
    logic [15:0]       pc_next;
    if (it.op == ITEM_LOAD) begin
      shadow_mem[it.load_address] = it.data_word;
    end else if (cpu_state.status == ST_RUN) begin
      if ({1'b0, cpu_state.program_counter} >= prog_len) begin
        cpu_state.status = ST_SEGV;
      end else begin
        w = shadow_mem[cpu_state.program_counter];
        opc = w[7:0];
        opd = {{8{w[31]}}, w[31:8]};
        if (opc > OPC_HALT) begin
          cpu_state.status = ST_BADOP;
        end else if (opc == OPC_HALT) begin
          cpu_state.status = ST_HALT;
        end else begin
          pc_next = cpu_state.program_counter;
          case (opc)
            OPC_LDC: begin
              cpu_state.reg_b = cpu_state.reg_a;
              cpu_state.reg_a = opd;
            end
            OPC_ADC: cpu_state.reg_a = cpu_state.reg_a + opd;
            OPC_LDL: begin
              cpu_state.reg_b = cpu_state.reg_a;
              cpu_state.reg_a = shadow_mem[cpu_state.stack_pointer + opd[15:0]];
            end
            OPC_STL: begin
              shadow_mem[cpu_state.stack_pointer + opd[15:0]] = cpu_state.reg_a;
              cpu_state.reg_a = cpu_state.reg_b;
            end
            OPC_LDNL: cpu_state.reg_a = shadow_mem[cpu_state.reg_a[15:0] + opd[15:0]];
            OPC_STNL: shadow_mem[cpu_state.reg_a[15:0] + opd[15:0]] = cpu_state.reg_b;
            OPC_ADD: cpu_state.reg_a = cpu_state.reg_b + cpu_state.reg_a;
            OPC_SUB: cpu_state.reg_a = cpu_state.reg_b - cpu_state.reg_a;
            OPC_SHL: cpu_state.reg_a = cpu_state.reg_b << cpu_state.reg_a[4:0];
            OPC_SHR: cpu_state.reg_a = cpu_state.reg_b >>> cpu_state.reg_a[4:0];
            OPC_ADJ: cpu_state.stack_pointer = cpu_state.stack_pointer + opd[15:0];
            OPC_A2SP: begin
              cpu_state.stack_pointer = cpu_state.reg_a[15:0];
              cpu_state.reg_a = cpu_state.reg_b;
            end
            OPC_SP2A: begin
              cpu_state.reg_b = cpu_state.reg_a;
              cpu_state.reg_a = {16'd0, cpu_state.stack_pointer};
            end
            OPC_CALL: begin
              cpu_state.reg_b = cpu_state.reg_a;
              cpu_state.reg_a = {16'd0, cpu_state.program_counter};
              pc_next = pc_next + opd[15:0];
            end
            OPC_RETURN: begin
              pc_next = cpu_state.reg_a[15:0];
              cpu_state.reg_a = cpu_state.reg_b;
            end
            OPC_BRZ: if (cpu_state.reg_a == 0) pc_next = pc_next + opd[15:0];
            OPC_BRLZ: if (cpu_state.reg_a[31]) pc_next = pc_next + opd[15:0];
            default: pc_next = pc_next + opd[15:0];
          endcase
          cpu_state.executed_count = cpu_state.executed_count + 1;
          cpu_state.program_counter = pc_next + 16'd1;
        end
      end
    end
    return cpu_state;
  endfunction

  function automatic logic [15:0] pc_after(logic [WORD_W-1:0] w);
    logic [15:0] pc   = cpu_state.program_counter;
    logic [15:0] jump = cpu_state.program_counter + w[23:8] + 16'd1;
    case (w[7:0])
      OPC_CALL, OPC_BR: return jump;
      OPC_BRZ: return (cpu_state.reg_a == 0) ? jump : pc + 16'd1;
      OPC_BRLZ: return cpu_state.reg_a[31] ? jump : pc + 16'd1;
      OPC_RETURN: return cpu_state.reg_a[15:0] + 16'd1;
      default: return pc + 16'd1;
    endcase
  endfunction

  // An instruction is safe when it neither stops the machine nor leaves the program.
  function automatic bit keeps_running(logic [WORD_W-1:0] w);
    return (w[7:0] < OPC_HALT) && ({1'b0, pc_after(w)} < prog_len);
  endfunction

  function automatic logic [WORD_W-1:0] encode(opcode_t opc, logic [23:0] operand);
    return {operand, opc};
  endfunction

  function automatic logic [WORD_W-1:0] random_instruction();
    logic [OPC_W-1:0]  opc;
    logic [23:0]       operand;
    logic [15:0]       offset;
    logic [15:0]       target;
    logic [WORD_W-1:0] w;
    for (int tries = 0; tries < 16; tries++) begin
      opc = 8'($urandom_range(0, OPC_BR));
      offset = 16'($urandom_range(0, 16) - 8);
      case ($urandom_range(0, 3))
        0: operand = {{8{offset[15]}}, offset};
        1: operand = 24'($urandom);
        default: begin
          if (opc == OPC_LDNL || opc == OPC_STNL) begin
            operand = {8'($urandom),
                       16'(cpu_state.stack_pointer + offset - cpu_state.reg_a[15:0])};
          end else if (opc inside {OPC_CALL, OPC_BRZ, OPC_BRLZ, OPC_BR}) begin
            target = 16'($urandom_range(0, prog_len - 1));
            operand = {8'($urandom), 16'(target - cpu_state.program_counter - 16'd1)};
          end else begin
            operand = {{8{offset[15]}}, offset};
          end
        end
      endcase
      w = {operand, opc};
      if (keeps_running(w)) return w;
    end
    return encode(OPC_BR, {8'hFF, ~cpu_state.program_counter});
  endfunction

  function automatic cmd_item_t load_beat(logic [15:0] addr, logic [WORD_W-1:0] data);
    cmd_item_t it;
    it.op = ITEM_LOAD;
    it.load_address = addr;
    it.data_word = data;
    return it;
  endfunction

  function automatic cmd_item_t step_beat();
    cmd_item_t it;
    it.op = ITEM_STEP;
    it.load_address = 16'($urandom);
    it.data_word = $urandom;
    return it;
  endfunction

  task automatic send_beat(cmd_item_t it, bit has_want = 1'b0, rsp_item_t want = '0);
    rsp_item_t predicted;
    if (send_calm > 0) begin
      send_calm--;
    end else if ($urandom_range(0, 99) < 3) begin
      send_calm = $urandom_range(10, 40);
    end else if ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    cmd_item <= it;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    predicted = execute_beat(it);
    pending_results.push_back(has_want ? want : predicted);
    beats_sent++;
    if (it.op == ITEM_STEP) steps_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    cmd_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [PLEN_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PROG_LEN) begin
      prog_len = value;
    end else begin
      cpu_state.stack_pointer = value[15:0];
    end
    @(negedge clk);
  endtask

  task automatic add_row(cmd_item_t it);
    script_row_t row;
    row.item = it;
    row.has_want = 1'b0;
    row.want = '0;
    script.push_back(row);
  endtask

  task automatic add_instruction(logic [15:0] addr, opcode_t opc, logic [23:0] operand);
    add_row(load_beat(addr, encode(opc, operand)));
    add_row(step_beat());
  endtask

  // Straight-line program that touches the operand extremes, both conditional
  // branches taken, an SP-relative wrap, and a call that wraps the PC to the top word.
  task automatic build_script();
    script_row_t first;
    first.item = load_beat(16'hFFFF, encode(OPC_RETURN, 24'h7FFFFF));
    first.has_want = 1'b1;
    first.want = '{status: ST_RUN, program_counter: 16'd0, stack_pointer: SP_RESET,
                   reg_a: 32'd0, reg_b: 32'd0, executed_count: 32'd0};
    script.push_back(first);
    add_instruction(16'd0, OPC_LDC, 24'h800000);
    add_instruction(16'd1, OPC_LDC, 24'h7FFFFF);
    add_instruction(16'd2, OPC_ADD, 24'd0);
    add_instruction(16'd3, OPC_BRLZ, 24'd1);
    add_instruction(16'd5, OPC_SHR, 24'd0);
    add_instruction(16'd6, OPC_STL, 24'hFFFFFF);
    add_instruction(16'd7, OPC_LDL, 24'hFFFFFF);
    add_instruction(16'd8, OPC_ADC, 24'd1);
    add_instruction(16'd9, OPC_BRZ, 24'd1);
    add_instruction(16'd11, OPC_ADJ, 24'hFFEFFF);
    add_instruction(16'd12, OPC_CALL, 24'hFFFFF2);
    add_row(step_beat());
  endtask

  task automatic run_random(int beats);
    int          issued;
    int          pick;
    logic [15:0] addr;
    issued = 0;
    while (issued < beats) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        addr = ($urandom_range(0, 1) == 1)
             ? 16'($urandom)
             : 16'(cpu_state.stack_pointer + $urandom_range(0, 16) - 8);
        send_beat(load_beat(addr, $urandom));
        issued++;
      end else if (pick < 25 && keeps_running(shadow_mem[cpu_state.program_counter])) begin
        send_beat(step_beat());
        issued++;
      end else begin
        send_beat(load_beat(cpu_state.program_counter, random_instruction()));
        send_beat(step_beat());
        issued += 2;
      end
    end
  endtask

  // Only reset clears a stop, so the run ends on one stop chosen at random and
  // then shows that the state holds across further steps and loads.
  task automatic run_stop();
    closing_stop = status_t'($urandom_range(ST_HALT, ST_SEGV));
    case (closing_stop)
      ST_HALT: send_beat(load_beat(cpu_state.program_counter,
                                   encode(OPC_HALT, 24'($urandom))));
      ST_BADOP: send_beat(load_beat(cpu_state.program_counter,
                                    {24'($urandom), 8'($urandom_range(OPC_HALT + 1, 255))}));
      default: begin
        wait_idle();
        write_reg(CFG_PROG_LEN, ($urandom_range(0, 1) == 1) ? 17'd0
                                                            : {1'b0, cpu_state.program_counter});
      end
    endcase
    send_beat(step_beat());
    send_beat(step_beat());
    send_beat(load_beat(cpu_state.program_counter, encode(OPC_ADC, 24'd1)));
    send_beat(step_beat());
    send_beat(load_beat(16'($urandom), $urandom));
    send_beat(step_beat());
  endtask

  task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result beat arrived with nothing expected");
        failures++;
      end else begin
        arrived = pending_results.pop_front();
        check_field("status", WORD_W'(arrived.status), WORD_W'(rsp_item.status));
        check_field("program_counter", WORD_W'(arrived.program_counter),
                    WORD_W'(rsp_item.program_counter));
        check_field("stack_pointer", WORD_W'(arrived.stack_pointer),
                    WORD_W'(rsp_item.stack_pointer));
        check_field("reg_a", arrived.reg_a, rsp_item.reg_a);
        check_field("reg_b", arrived.reg_b, rsp_item.reg_b);
        check_field("executed_count", arrived.executed_count, rsp_item.executed_count);
      end
    end
  end

  always @(negedge clk) begin
    if (recv_calm > 0) begin
      recv_calm--;
      rsp_stall <= 1'b0;
    end else if ($urandom_range(0, 99) < 3) begin
      recv_calm = $urandom_range(5, 30);
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  initial begin
    int new_len;
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd_item = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_PROG_LEN;
    cfg_data = '0;
    for (int i = 0; i < 65536; i++) shadow_mem[i] = '0;
    cpu_state = '{status: ST_RUN, program_counter: 16'd0, stack_pointer: SP_RESET,
                  reg_a: 32'd0, reg_b: 32'd0, executed_count: 32'd0};
    prog_len = '0;
    send_idle_pct = 33;
    recv_idle_pct = 60;
    send_calm = 0;
    recv_calm = 0;
    failures = 0;
    beats_sent = 0;
    steps_sent = 0;
    results_seen = 0;
    closing_stop = ST_RUN;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_reg(CFG_PROG_LEN, 17'd65536);
    write_reg(CFG_INIT_SP, {1'b0, SP_RESET});

    build_script();
    foreach (script[i]) send_beat(script[i].item, script[i].has_want, script[i].want);
    run_random(350);

    wait_idle();
    new_len = cpu_state.program_counter + 1 + $urandom_range(0, 4095);
    write_reg(CFG_PROG_LEN, (new_len > 65536) ? 17'd65536 : 17'(new_len));
    write_reg(CFG_INIT_SP, 17'd0);
    send_idle_pct = 60;
    recv_idle_pct = 33;
    run_random(370);

    wait_idle();
    write_reg(CFG_PROG_LEN, (cpu_state.program_counter < 16'hFFFF) ? 17'd65535 : 17'd65536);
    write_reg(CFG_INIT_SP, 17'd65535);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(350);
    run_stop();

    wait_idle();
    repeat (16) @(posedge clk);
    $display("Sent %0d beats, %0d of them instruction steps, under three idling mixes;",
             beats_sent, steps_sent);
    $display("%0d result beats compared, closing on stop status %0d held across later beats.",
             results_seen, closing_stop);
    if (failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* accumulator_stack_cpu_step_core.f */
rtl/core/acs_pkg.sv
rtl/core/acs_mem.sv
rtl/core/acs_exec.sv
rtl/core/acs_out_fifo.sv
rtl/core/accumulator_stack_cpu_step_core.sv
test/testbench.sv
